// ===== design/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for the quaternion to Euler angle block
// Widths of the datapath, CORDIC arctangent table and the scaled-terms bundle.
// ----------------------------------------------------------------------------
package qte_pkg;

  // field widths
  localparam int IN_W    = 16;
  localparam int ANG_W   = 16;
  localparam int PITCH_W = 15;

  // datapath widths
  localparam int RAW_W  = 34;  // raw matrix terms, |t| <= 2^32
  localparam int TERM_W = 32;  // block-scaled terms, |t| <= 2^30
  localparam int SQ_W   = 62;  // sum of two squares
  localparam int ROOT_W = 31;  // floor square root
  localparam int CX_W   = 34;  // CORDIC x/y
  localparam int Z_W    = 20;  // CORDIC angle, Q.16
  localparam int STEPS  = 16;  // CORDIC iterations

  // leading-one position that scaled terms are normalized to
  localparam logic [5:0] NORM_POS = 6'd29;

  // angle constants
  localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic [ANG_W-1:0]      PI_Q13      = 16'd25736;
  localparam logic [ANG_W-1:0]      HALF_PI_Q13 = 16'd12868;

  // pipeline depths
  localparam int TERMS_LAT  = 5;
  localparam int CORDIC_LAT = STEPS + 2;

  // five rotation-matrix terms after block scaling
  typedef struct packed {
    logic signed [TERM_W-1:0] r00;
    logic signed [TERM_W-1:0] r10;
    logic signed [TERM_W-1:0] r20;
    logic signed [TERM_W-1:0] r21;
    logic signed [TERM_W-1:0] r22;
    logic                     deg;
  } terms_t;

  // atan(2^-i) in Q.16, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_q16(input int i);
    logic signed [Z_W-1:0] a;
    case (i)
      0:       a = 20'sd51472;
      1:       a = 20'sd30386;
      2:       a = 20'sd16055;
      3:       a = 20'sd8150;
      4:       a = 20'sd4091;
      5:       a = 20'sd2047;
      6:       a = 20'sd1024;
      7:       a = 20'sd512;
      8:       a = 20'sd256;
      9:       a = 20'sd128;
      10:      a = 20'sd64;
      11:      a = 20'sd32;
      12:      a = 20'sd16;
      13:      a = 20'sd8;
      14:      a = 20'sd4;
      15:      a = 20'sd2;
      default: a = 20'sd0;
    endcase
    return a;
  endfunction

endpackage

// ===== design/qte_terms.sv =====
// ----------------------------------------------------------------------------
// qte_terms: rotation-matrix terms with block scaling
// Five-stage pipe: products, sums, magnitude OR, leading-one search, shift.
// ----------------------------------------------------------------------------
module qte_terms (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [15:0]  qw,
  input  logic signed [15:0]  qx,
  input  logic signed [15:0]  qy,
  input  logic signed [15:0]  qz,
  output logic                out_valid,
  output qte_pkg::terms_t     terms_out
);

  localparam int RW = qte_pkg::RAW_W;

  function automatic logic [RW-1:0] mag(input logic signed [RW-1:0] v);
    return v[RW-1] ? RW'(-v) : RW'(v);
  endfunction

  function automatic logic signed [qte_pkg::TERM_W-1:0] norm(
    input logic signed [RW-1:0] t, input logic rsh, input logic [4:0] amt);
    logic signed [RW-1:0] s;
    s = rsh ? (t >>> amt) : (t <<< amt);
    return s[qte_pkg::TERM_W-1:0];
  endfunction

  logic [qte_pkg::TERMS_LAT-1:0] v;

  // stage 1
  logic signed [31:0] p_ww, p_xx, p_yy, p_zz, p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;
  logic               deg1;
  // stage 2
  logic signed [RW-1:0] a00, a10, a20, a21, a22;
  logic                 deg2;
  // stage 3
  logic signed [RW-1:0] b00, b10, b20, b21, b22;
  logic [RW-1:0]        mag_or;
  logic                 deg3;
  // stage 4
  logic signed [RW-1:0] c00, c10, c20, c21, c22;
  logic                 rsh;
  logic [4:0]           amt;
  logic                 deg4;

  logic [5:0] pos;

  // leading one of the OR of magnitudes = leading one of the max
  always_comb begin
    pos = '0;
    for (int i = 0; i < RW; i++) begin
      if (mag_or[i]) pos = 6'(i);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[qte_pkg::TERMS_LAT-2:0], in_valid};
    end
  end

  assign out_valid = v[qte_pkg::TERMS_LAT-1];

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      p_ww <= qw * qw;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_zz <= qz * qz;
      p_xy <= qx * qy;
      p_wz <= qw * qz;
      p_xz <= qx * qz;
      p_wy <= qw * qy;
      p_yz <= qy * qz;
      p_wx <= qw * qx;
      deg1 <= (qw == 16'sd0) && (qx == 16'sd0) && (qy == 16'sd0) && (qz == 16'sd0);

      a00  <= RW'(p_ww) + RW'(p_xx) - RW'(p_yy) - RW'(p_zz);
      a10  <= (RW'(p_xy) + RW'(p_wz)) <<< 1;
      a20  <= (RW'(p_xz) - RW'(p_wy)) <<< 1;
      a21  <= (RW'(p_yz) + RW'(p_wx)) <<< 1;
      a22  <= RW'(p_ww) + RW'(p_zz) - RW'(p_xx) - RW'(p_yy);
      deg2 <= deg1;

      b00    <= a00;
      b10    <= a10;
      b20    <= a20;
      b21    <= a21;
      b22    <= a22;
      mag_or <= mag(a00) | mag(a10) | mag(a20) | mag(a21) | mag(a22);
      deg3   <= deg2;

      c00  <= b00;
      c10  <= b10;
      c20  <= b20;
      c21  <= b21;
      c22  <= b22;
      rsh  <= pos > qte_pkg::NORM_POS;
      amt  <= (pos > qte_pkg::NORM_POS) ? 5'(pos - qte_pkg::NORM_POS)
                                        : 5'(qte_pkg::NORM_POS - pos);
      deg4 <= deg3;

      terms_out.r00 <= norm(c00, rsh, amt);
      terms_out.r10 <= norm(c10, rsh, amt);
      terms_out.r20 <= norm(c20, rsh, amt);
      terms_out.r21 <= norm(c21, rsh, amt);
      terms_out.r22 <= norm(c22, rsh, amt);
      terms_out.deg <= deg4;
    end
  end

endmodule

// ===== design/qte_sqrt.sv =====
// ----------------------------------------------------------------------------
// qte_sqrt: pipelined floor square root of r21^2 + r22^2
// Two stages of squares and sum, then one result bit per stage.
// ----------------------------------------------------------------------------
module qte_sqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  qte_pkg::terms_t                  terms_in,
  output logic                             out_valid,
  output qte_pkg::terms_t                  terms_out,
  output logic [qte_pkg::ROOT_W-1:0]       root
);

  localparam int NB = qte_pkg::ROOT_W;
  localparam int SW = qte_pkg::SQ_W;

  logic                     va, vb;
  logic signed [63:0]       sq21, sq22;
  qte_pkg::terms_t          ta, tb;
  logic [SW-1:0]            n;

  logic [NB-1:0]            sv;
  logic [SW-1:0]            rem  [NB];
  logic [NB-1:0]            rt   [NB];
  qte_pkg::terms_t          ts   [NB];
  logic [SW-1:0]            nrem [NB];
  logic [NB-1:0]            nrt  [NB];

  // one restoring step per stage k: try setting bit NB-1-k of the root
  always_comb begin
    logic [SW-1:0] r_in;
    logic [NB-1:0] q_in;
    logic [63:0]   trial;
    for (int k = 0; k < NB; k++) begin
      r_in  = (k == 0) ? n : rem[(k == 0) ? 0 : k - 1];
      q_in  = (k == 0) ? '0 : rt[(k == 0) ? 0 : k - 1];
      trial = (64'(q_in) << (NB - k)) | (64'd1 << (2 * (NB - 1 - k)));
      if (64'(r_in) >= trial) begin
        nrem[k] = r_in - trial[SW-1:0];
        nrt[k]  = q_in | (NB'(1) << (NB - 1 - k));
      end else begin
        nrem[k] = r_in;
        nrt[k]  = q_in;
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      sv <= '0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      sv <= {sv[NB-2:0], vb};
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      sq21 <= terms_in.r21 * terms_in.r21;
      sq22 <= terms_in.r22 * terms_in.r22;
      ta   <= terms_in;
      n    <= sq21[SW-1:0] + sq22[SW-1:0];
      tb   <= ta;
      for (int k = 0; k < NB; k++) begin
        rem[k] <= nrem[k];
        rt[k]  <= nrt[k];
        ts[k]  <= (k == 0) ? tb : ts[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign out_valid = sv[NB-1];
  assign terms_out = ts[NB-1];
  assign root      = rt[NB-1];

endmodule

// ===== design/qte_cordic.sv =====
// ----------------------------------------------------------------------------
// qte_cordic: pipelined CORDIC atan2 in vectoring mode
// Quadrant pre-rotation, one iteration per stage, then round and clamp; a zero vector gives zero.
// ----------------------------------------------------------------------------
module qte_cordic (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [qte_pkg::CX_W-1:0]   in_y,
  input  logic signed [qte_pkg::CX_W-1:0]   in_x,
  input  logic [qte_pkg::ANG_W-1:0]         lim,
  output logic signed [qte_pkg::ANG_W-1:0]  angle
);

  localparam int XW = qte_pkg::CX_W;
  localparam int ZW = qte_pkg::Z_W;
  localparam int NS = qte_pkg::STEPS;

  logic signed [XW-1:0] xs  [NS+1];
  logic signed [XW-1:0] ys  [NS+1];
  logic signed [ZW-1:0] zs  [NS+1];
  logic                 zf  [NS+1];
  logic signed [XW-1:0] nx  [NS+1];
  logic signed [XW-1:0] ny  [NS+1];
  logic signed [ZW-1:0] nz  [NS+1];

  logic signed [ZW-1:0] rz, lim_z;

  // pre-rotation and iterations
  always_comb begin
    if (in_x < 0) begin
      if (in_y >= 0) begin
        nx[0] = in_y;
        ny[0] = -in_x;
        nz[0] = qte_pkg::HALF_PI_Q16;
      end else begin
        nx[0] = -in_y;
        ny[0] = in_x;
        nz[0] = -qte_pkg::HALF_PI_Q16;
      end
    end else begin
      nx[0] = in_x;
      ny[0] = in_y;
      nz[0] = '0;
    end
    for (int k = 1; k <= NS; k++) begin
      if (ys[k-1] < 0) begin
        nx[k] = xs[k-1] - (ys[k-1] >>> (k - 1));
        ny[k] = ys[k-1] + (xs[k-1] >>> (k - 1));
        nz[k] = zs[k-1] - qte_pkg::atan_q16(k - 1);
      end else begin
        nx[k] = xs[k-1] + (ys[k-1] >>> (k - 1));
        ny[k] = ys[k-1] - (xs[k-1] >>> (k - 1));
        nz[k] = zs[k-1] + qte_pkg::atan_q16(k - 1);
      end
    end
  end

  // round Q.16 to Q.13
  assign rz    = (zs[NS] + $signed(ZW'(4))) >>> 3;
  assign lim_z = ZW'(lim);

  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (in_x == 0) && (in_y == 0);
      for (int k = 0; k <= NS; k++) begin
        xs[k] <= nx[k];
        ys[k] <= ny[k];
        zs[k] <= nz[k];
        if (k > 0) zf[k] <= zf[(k > 0) ? k - 1 : 0];
      end
      if (zf[NS]) begin
        angle <= '0;
      end else if (rz > lim_z) begin
        angle <= qte_pkg::ANG_W'(lim_z);
      end else if (rz < -lim_z) begin
        angle <= qte_pkg::ANG_W'(-lim_z);
      end else begin
        angle <= qte_pkg::ANG_W'(rz);
      end
    end
  end

endmodule

// ===== design/quaternion_to_euler_angles.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles: quaternion to ZYX roll, pitch and yaw
// Scaled matrix terms, pipelined square root and three CORDIC atan2 units.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)             | tuser
//  s_axis   | in  | quat_w, quat_x, quat_y, quat_z | -
//  m_axis   | out | roll, pitch, yaw, pad to 48    | degenerate
//
// One beat per cycle while m_axis accepts; the path is 5 term stages, 33 square
// root stages, 18 CORDIC stages and the output register. Latency is set by the
// one-bit-per-stage square root feeding the pitch CORDIC.
// Reset (rst, synchronous) clears valid bits only. A stall on m_axis parks
// one beat in a skid register, then holds the whole pipe without loss.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // roll, pitch, yaw, zero pad
  output logic        m_tuser    // degenerate
);

  localparam int CL = qte_pkg::CORDIC_LAT;
  localparam int XW = qte_pkg::CX_W;

  logic                         en;
  logic                         t_valid, q_valid;
  qte_pkg::terms_t              t_terms, q_terms;
  logic [qte_pkg::ROOT_W-1:0]   q_root;
  logic [CL-1:0]                cv;
  logic [CL-1:0]                cdeg;
  logic signed [15:0]           roll_a, pitch_a, yaw_a;
  logic [47:0]                  p_data;
  logic                         p_valid;
  logic                         skid_valid;
  logic [47:0]                  skid_data;
  logic                         skid_deg;

  assign en       = !skid_valid;
  assign s_tready = en;

  qte_terms u_terms (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .qw        (s_tdata[15:0]),
    .qx        (s_tdata[31:16]),
    .qy        (s_tdata[47:32]),
    .qz        (s_tdata[63:48]),
    .out_valid (t_valid),
    .terms_out (t_terms)
  );

  qte_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t_valid),
    .terms_in  (t_terms),
    .out_valid (q_valid),
    .terms_out (q_terms),
    .root      (q_root)
  );

  qte_cordic u_roll (
    .clk   (clk),
    .en    (en),
    .in_y  (XW'(q_terms.r21)),
    .in_x  (XW'(q_terms.r22)),
    .lim   (qte_pkg::PI_Q13),
    .angle (roll_a)
  );

  qte_cordic u_pitch (
    .clk   (clk),
    .en    (en),
    .in_y  (-XW'(q_terms.r20)),
    .in_x  (XW'(q_root)),
    .lim   (qte_pkg::HALF_PI_Q13),
    .angle (pitch_a)
  );

  qte_cordic u_yaw (
    .clk   (clk),
    .en    (en),
    .in_y  (XW'(q_terms.r10)),
    .in_x  (XW'(q_terms.r00)),
    .lim   (qte_pkg::PI_Q13),
    .angle (yaw_a)
  );

  // valid and degenerate flag alongside the CORDIC stages
  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= '0;
    end else if (en) begin
      cv <= {cv[CL-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cdeg <= {cdeg[CL-2:0], q_terms.deg};
    end
  end

  // beat handed from the pipe to the output side
  assign p_valid = cv[CL-1] && en;
  assign p_data  = cdeg[CL-1] ? 48'd0
                 : {1'b0, yaw_a, pitch_a[qte_pkg::PITCH_W-1:0], roll_a};

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid   <= skid_valid || p_valid;
      skid_valid <= 1'b0;
    end else if (p_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata <= skid_valid ? skid_data : p_data;
      m_tuser <= skid_valid ? skid_deg : cdeg[CL-1];
    end else if (p_valid) begin
      skid_data <= p_data;
      skid_deg  <= cdeg[CL-1];
    end
  end

endmodule
